@@ src/llss_pkg.sv @@
// Shared constants, types and command structures of the least-loaded server selector.
`default_nettype none

package llss_pkg;

    localparam int SERVERS   = 16;
    localparam int SLOT_W    = (SERVERS > 1) ? $clog2(SERVERS) : 1;
    localparam int SEL_W     = 4;
    localparam int CNT_W     = 16;
    localparam int TOT_W     = 20;
    localparam int IP_W      = 32;
    localparam int PORT_W    = 16;
    localparam int USE_W     = 2 * CNT_W;
    localparam int INFO_W    = 2 * IP_W + PORT_W;

    localparam logic [CNT_W-1:0] USERS_MAX = {CNT_W{1'b1}};
    localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_REGISTER = 2'd0,
        REQ_REMOVE   = 2'd1,
        REQ_UPDATE   = 2'd2,
        REQ_SELECT   = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_NONE = 2'd1,
        STATUS_FULL = 2'd2
    } t_status;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_READ     = 7'b0000010,
        S_APPLY    = 7'b0000100,
        S_SCAN     = 7'b0001000,
        S_SCAN_END = 7'b0010000,
        S_FETCH    = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    typedef struct packed {
        logic take_req;
        logic read_slot;
        logic apply;
        logic scan_issue;
        logic fetch;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_req_type req_type;
        logic      scan_last;
        logic      out_free;
    } t_stat;

endpackage

`default_nettype wire

@@ src/llss_req_if.sv @@
// Request channel interface: handshake and request word fields.
`default_nettype none

interface llss_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [3:0]  server_slot;
    logic [31:0] primary_addr;
    logic [31:0] backup_addr;
    logic [15:0] server_port;
    logic [15:0] start_users;
    logic [15:0] user_limit;
    logic        count_up;

    modport source (
        output valid, req_type, server_slot, primary_addr, backup_addr,
               server_port, start_users, user_limit, count_up,
        input  ready
    );

    modport sink (
        input  valid, req_type, server_slot, primary_addr, backup_addr,
               server_port, start_users, user_limit, count_up,
        output ready
    );
endinterface

`default_nettype wire

@@ src/llss_rsp_if.sv @@
// Response channel interface: handshake and result word fields.
`default_nettype none

interface llss_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  chosen_slot;
    logic [31:0] chosen_primary;
    logic [31:0] chosen_backup;
    logic [15:0] chosen_port;
    logic [19:0] total_users;

    modport source (
        output valid, status, chosen_slot, chosen_primary, chosen_backup,
               chosen_port, total_users,
        input  ready
    );

    modport sink (
        input  valid, status, chosen_slot, chosen_primary, chosen_backup,
               chosen_port, total_users,
        output ready
    );
endinterface

`default_nettype wire

@@ src/least_loaded_server_selector.sv @@
// Top level of the least-loaded server selector: controller, datapath and channel wiring.
//
//   Channel  Direction  Word contents
//   i_req    in         req_type, server_slot, addresses, port, user counts, count_up
//   o_rsp    out        status, chosen slot, its addresses and port, total_users
//
// Register, remove and update words pass through the READ, APPLY and DONE states.
// Select words pass through SCAN, SCAN_END, FETCH and DONE: the scan reads one slot
// per cycle from the usage RAM read port, then FETCH reads the chosen slot's addresses.
// One word is in work at a time; the next is accepted once the result is registered.
// A stalled result holds in the output register; reset clears all slot valid marks.
`default_nettype none

module least_loaded_server_selector (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    llss_req_if.sink   i_req,
    llss_rsp_if.source o_rsp
);
    import llss_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  req_ready;

    llss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    llss_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_req_type       (i_req.req_type),
        .i_server_slot    (i_req.server_slot),
        .i_primary_addr   (i_req.primary_addr),
        .i_backup_addr    (i_req.backup_addr),
        .i_server_port    (i_req.server_port),
        .i_start_users    (i_req.start_users),
        .i_user_limit     (i_req.user_limit),
        .i_count_up       (i_req.count_up),
        .i_rsp_ready      (o_rsp.ready),
        .o_rsp_valid      (o_rsp.valid),
        .o_status         (o_rsp.status),
        .o_chosen_slot    (o_rsp.chosen_slot),
        .o_chosen_primary (o_rsp.chosen_primary),
        .o_chosen_backup  (o_rsp.chosen_backup),
        .o_chosen_port    (o_rsp.chosen_port),
        .o_total_users    (o_rsp.total_users)
    );

    assign i_req.ready = req_ready;

endmodule

`default_nettype wire

@@ src/llss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module llss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ src/llss_ctrl.sv @@
// Controller state machine that sequences request handling and the table scan.
`default_nettype none

module llss_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    output logic                o_req_ready,
    input  wire llss_pkg::t_stat i_stat,
    output llss_pkg::t_cmd      o_cmd
);
    import llss_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    cmd.take_req = 1'b1;
                    n_state = (i_stat.req_type == REQ_SELECT) ? S_SCAN : S_READ;
                end
            end
            S_READ: begin
                cmd.read_slot = 1'b1;
                n_state = S_APPLY;
            end
            S_APPLY: begin
                cmd.apply = 1'b1;
                n_state = S_DONE;
            end
            S_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_FETCH;
            end
            S_FETCH: begin
                cmd.fetch = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

@@ src/llss_dp.sv @@
// Datapath: slot table, user total, scan for the least-loaded slot and result register.
`default_nettype none

module llss_dp (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire llss_pkg::t_cmd            i_cmd,
    output llss_pkg::t_stat                o_stat,
    input  wire logic [1:0]                i_req_type,
    input  wire logic [3:0]                i_server_slot,
    input  wire logic [llss_pkg::IP_W-1:0] i_primary_addr,
    input  wire logic [llss_pkg::IP_W-1:0] i_backup_addr,
    input  wire logic [llss_pkg::PORT_W-1:0] i_server_port,
    input  wire logic [llss_pkg::CNT_W-1:0]  i_start_users,
    input  wire logic [llss_pkg::CNT_W-1:0]  i_user_limit,
    input  wire logic                      i_count_up,
    input  wire logic                      i_rsp_ready,
    output logic                           o_rsp_valid,
    output logic [1:0]                     o_status,
    output logic [llss_pkg::SEL_W-1:0]     o_chosen_slot,
    output logic [llss_pkg::IP_W-1:0]      o_chosen_primary,
    output logic [llss_pkg::IP_W-1:0]      o_chosen_backup,
    output logic [llss_pkg::PORT_W-1:0]    o_chosen_port,
    output logic [llss_pkg::TOT_W-1:0]     o_total_users
);
    import llss_pkg::*;

    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [TOT_W:0] sum;
        sum = {1'b0, a} + (TOT_W+1)'(b);
        return sum[TOT_W] ? TOTAL_MAX : sum[TOT_W-1:0];
    endfunction

    function automatic logic [TOT_W-1:0] sat_sub(input logic [TOT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [TOT_W:0] diff;
        diff = {1'b0, a} - (TOT_W+1)'(b);
        return diff[TOT_W] ? '0 : diff[TOT_W-1:0];
    endfunction

    // Captured request word.
    t_req_type          r_kind;
    logic [3:0]         r_slot;
    logic [IP_W-1:0]    r_prim;
    logic [IP_W-1:0]    r_back;
    logic [PORT_W-1:0]  r_port;
    logic [CNT_W-1:0]   r_start;
    logic [CNT_W-1:0]   r_limit;
    logic               r_up;

    logic [SERVERS-1:0] r_valid;
    logic [SERVERS-1:0] n_valid;
    logic [TOT_W-1:0]   r_total;
    logic [TOT_W-1:0]   n_total;

    // Scan pipeline.
    logic [SLOT_W-1:0]  r_idx;
    logic               r_pend;
    logic [SLOT_W-1:0]  r_pend_idx;
    logic               r_any;
    logic               r_found;
    logic [SLOT_W-1:0]  r_best;
    logic [CNT_W-1:0]   r_best_users;

    // Result register.
    logic               r_out_valid;
    logic [1:0]         r_status;
    logic [SEL_W-1:0]   r_chosen;
    logic [IP_W-1:0]    r_cprim;
    logic [IP_W-1:0]    r_cback;
    logic [PORT_W-1:0]  r_cport;
    logic [TOT_W-1:0]   r_ctotal;

    logic [SLOT_W-1:0]  slot_a;
    logic               in_table;
    logic               cur_valid;

    logic               use_we;
    logic [USE_W-1:0]   use_wdata;
    logic [SLOT_W-1:0]  use_raddr;
    logic [USE_W-1:0]   use_rdata;
    logic [CNT_W-1:0]   old_users;
    logic [CNT_W-1:0]   old_limit;

    logic               info_we;
    logic [INFO_W-1:0]  info_rdata;

    logic [CNT_W-1:0]   scan_users;
    logic [CNT_W-1:0]   scan_limit;
    logic               scan_take;

    assign slot_a    = SLOT_W'(r_slot);
    assign in_table  = (int'(r_slot) < SERVERS);
    assign cur_valid = r_valid[slot_a];
    assign old_users = use_rdata[USE_W-1:CNT_W];
    assign old_limit = use_rdata[CNT_W-1:0];
    assign use_raddr = i_cmd.scan_issue ? r_idx : slot_a;

    llss_ram #(.WIDTH(USE_W), .DEPTH(SERVERS)) u_use_ram (
        .i_clk   (i_clk),
        .i_we    (use_we),
        .i_waddr (slot_a),
        .i_wdata (use_wdata),
        .i_re    (i_cmd.read_slot | i_cmd.scan_issue),
        .i_raddr (use_raddr),
        .o_rdata (use_rdata)
    );

    llss_ram #(.WIDTH(INFO_W), .DEPTH(SERVERS)) u_info_ram (
        .i_clk   (i_clk),
        .i_we    (info_we),
        .i_waddr (slot_a),
        .i_wdata ({r_prim, r_back, r_port}),
        .i_re    (i_cmd.fetch),
        .i_raddr (r_best),
        .o_rdata (info_rdata)
    );

    always_comb begin
        n_total   = r_total;
        n_valid   = r_valid;
        use_we    = 1'b0;
        use_wdata = {r_start, r_limit};
        info_we   = 1'b0;
        if (i_cmd.apply && in_table) begin
            case (r_kind)
                REQ_REGISTER: begin
                    use_we  = 1'b1;
                    info_we = 1'b1;
                    n_valid[slot_a] = 1'b1;
                    n_total = sat_add(cur_valid ? sat_sub(r_total, old_users) : r_total,
                                      r_start);
                end
                REQ_REMOVE: begin
                    if (cur_valid) begin
                        n_valid[slot_a] = 1'b0;
                        n_total = sat_sub(r_total, old_users);
                    end
                end
                REQ_UPDATE: begin
                    if (cur_valid) begin
                        if (r_up) begin
                            if (old_users != USERS_MAX) begin
                                use_we    = 1'b1;
                                use_wdata = {old_users + CNT_W'(1), old_limit};
                                n_total   = sat_add(r_total, CNT_W'(1));
                            end
                        end else if (old_users != '0) begin
                            use_we    = 1'b1;
                            use_wdata = {old_users - CNT_W'(1), old_limit};
                            n_total   = sat_sub(r_total, CNT_W'(1));
                        end
                    end
                end
                default: begin
                    n_total = r_total;
                end
            endcase
        end
    end

    assign scan_users = old_users;
    assign scan_limit = old_limit;
    assign scan_take  = r_pend && r_valid[r_pend_idx] && (scan_users < scan_limit)
                        && (!r_found || (scan_users < r_best_users));

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_kind  <= t_req_type'(i_req_type);
            r_slot  <= i_server_slot;
            r_prim  <= i_primary_addr;
            r_back  <= i_backup_addr;
            r_port  <= i_server_port;
            r_start <= i_start_users;
            r_limit <= i_user_limit;
            r_up    <= i_count_up;
        end
        if (i_cmd.scan_issue) begin
            r_pend_idx <= r_idx;
        end
        if (scan_take) begin
            r_best       <= r_pend_idx;
            r_best_users <= scan_users;
        end
        if (i_cmd.load_out) begin
            r_ctotal <= r_total;
            if (r_kind == REQ_SELECT && r_found) begin
                r_chosen <= SEL_W'(r_best);
                r_cprim  <= info_rdata[INFO_W-1 -: IP_W];
                r_cback  <= info_rdata[PORT_W +: IP_W];
                r_cport  <= info_rdata[PORT_W-1:0];
            end else begin
                r_chosen <= '0;
                r_cprim  <= '0;
                r_cback  <= '0;
                r_cport  <= '0;
            end
            if (r_kind != REQ_SELECT) begin
                r_status <= STATUS_OK;
            end else if (!r_any) begin
                r_status <= STATUS_NONE;
            end else if (!r_found) begin
                r_status <= STATUS_FULL;
            end else begin
                r_status <= STATUS_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_total     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_any       <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_total <= n_total;
            r_pend  <= i_cmd.scan_issue;
            if (i_cmd.take_req) begin
                r_idx   <= '0;
                r_any   <= 1'b0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.scan_issue) begin
                    r_idx <= r_idx + SLOT_W'(1);
                end
                if (r_pend && r_valid[r_pend_idx]) begin
                    r_any <= 1'b1;
                end
                if (scan_take) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.req_type  = t_req_type'(i_req_type);
    assign o_stat.scan_last = (r_idx == SLOT_W'(SERVERS - 1));
    assign o_stat.out_free  = !r_out_valid || i_rsp_ready;

    assign o_rsp_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_chosen_slot    = r_chosen;
    assign o_chosen_primary = r_cprim;
    assign o_chosen_backup  = r_cback;
    assign o_chosen_port    = r_cport;
    assign o_total_users    = r_ctotal;

endmodule

`default_nettype wire

@@ tb/least_loaded_server_selector_checker.sv @@
// Checker that predicts each reply word of the least-loaded server selector and compares it.
module least_loaded_server_selector_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    llss_req_if       i_req,
    llss_rsp_if       i_rsp,
    output int        o_fail_count,
    output int        o_pending
);
    import llss_pkg::*;

    typedef struct packed {
        logic [1:0]        status;
        logic [SEL_W-1:0]  slot;
        logic [IP_W-1:0]   primary;
        logic [IP_W-1:0]   backup;
        logic [PORT_W-1:0] port;
        logic [TOT_W-1:0]  total;
    } t_reply;

    logic              srv_valid   [SERVERS];
    logic [CNT_W-1:0]  srv_users   [SERVERS];
    logic [CNT_W-1:0]  srv_limit   [SERVERS];
    logic [IP_W-1:0]   srv_primary [SERVERS];
    logic [IP_W-1:0]   srv_backup  [SERVERS];
    logic [PORT_W-1:0] srv_port    [SERVERS];
    logic [TOT_W-1:0]  users_sum;
    t_reply            pending_replies [$];

    function automatic logic [TOT_W-1:0] total_plus(logic [TOT_W-1:0] t, logic [CNT_W-1:0] n);
        logic [TOT_W:0] sum;
        sum = {1'b0, t} + (TOT_W+1)'(n);
        return (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOT_W-1:0];
    endfunction

    function automatic logic [TOT_W-1:0] total_minus(logic [TOT_W-1:0] t, logic [CNT_W-1:0] n);
        return (TOT_W'(n) > t) ? '0 : t - TOT_W'(n);
    endfunction

    function automatic t_reply apply_request(
        input t_req_type         kind,
        input logic [3:0]        slot,
        input logic [IP_W-1:0]   prim,
        input logic [IP_W-1:0]   back,
        input logic [PORT_W-1:0] port,
        input logic [CNT_W-1:0]  users,
        input logic [CNT_W-1:0]  limit,
        input logic              up
    );
        t_reply         r;
        logic           any_valid;
        logic           found;
        logic [CNT_W:0] best;
        int             pick;
        r = '0;
        r.status = STATUS_OK;
        case (kind)
            REQ_REGISTER: begin
                if (srv_valid[slot]) begin
                    users_sum = total_minus(users_sum, srv_users[slot]);
                end
                srv_valid[slot]   = 1'b1;
                srv_primary[slot] = prim;
                srv_backup[slot]  = back;
                srv_port[slot]    = port;
                srv_users[slot]   = users;
                srv_limit[slot]   = limit;
                users_sum = total_plus(users_sum, users);
            end
            REQ_REMOVE: begin
                if (srv_valid[slot]) begin
                    users_sum = total_minus(users_sum, srv_users[slot]);
                    srv_valid[slot] = 1'b0;
                end
            end
            REQ_UPDATE: begin
                if (srv_valid[slot]) begin
                    if (up && srv_users[slot] != USERS_MAX) begin
                        srv_users[slot] = srv_users[slot] + CNT_W'(1);
                        users_sum = total_plus(users_sum, CNT_W'(1));
                    end else if (!up && srv_users[slot] != '0) begin
                        srv_users[slot] = srv_users[slot] - CNT_W'(1);
                        users_sum = total_minus(users_sum, CNT_W'(1));
                    end
                end
            end
            default: begin
                any_valid = 1'b0;
                found = 1'b0;
                best = '1;
                pick = 0;
                for (int i = 0; i < SERVERS; i++) begin
                    if (srv_valid[i]) begin
                        any_valid = 1'b1;
                        if (srv_users[i] < srv_limit[i] && {1'b0, srv_users[i]} < best) begin
                            best = {1'b0, srv_users[i]};
                            pick = i;
                            found = 1'b1;
                        end
                    end
                end
                if (!any_valid) begin
                    r.status = STATUS_NONE;
                end else if (!found) begin
                    r.status = STATUS_FULL;
                end else begin
                    r.slot    = SEL_W'(pick);
                    r.primary = srv_primary[pick];
                    r.backup  = srv_backup[pick];
                    r.port    = srv_port[pick];
                end
            end
        endcase
        r.total = users_sum;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < SERVERS; i++) begin
                srv_valid[i] = 1'b0;
            end
            users_sum = '0;
            pending_replies.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_replies.size() == 0) begin
                    $display("%0t: reply word with none expected: status %0d slot %0d total %0d",
                             $time, i_rsp.status, i_rsp.chosen_slot, i_rsp.total_users);
                    o_fail_count++;
                end else begin
                    want = pending_replies.pop_front();
                    check_field("status", 32'(want.status), 32'(i_rsp.status));
                    check_field("chosen_slot", 32'(want.slot), 32'(i_rsp.chosen_slot));
                    check_field("chosen_primary", want.primary, i_rsp.chosen_primary);
                    check_field("chosen_backup", want.backup, i_rsp.chosen_backup);
                    check_field("chosen_port", 32'(want.port), 32'(i_rsp.chosen_port));
                    check_field("total_users", 32'(want.total), 32'(i_rsp.total_users));
                end
            end
            if (i_req.valid && i_req.ready) begin
                pending_replies.push_back(apply_request(t_req_type'(i_req.req_type),
                    i_req.server_slot, i_req.primary_addr, i_req.backup_addr,
                    i_req.server_port, i_req.start_users, i_req.user_limit, i_req.count_up));
            end
        end
        o_pending = pending_replies.size();
    end

endmodule

@@ tb/least_loaded_server_selector_test.sv @@
// Top of the least-loaded server selector testbench: clock, reset, request words and verdict.
module least_loaded_server_selector_test;
    import llss_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int WORDS_PER_PHASE = 500;

    typedef struct {
        t_req_type   kind;
        logic [3:0]  slot;
        logic [31:0] prim;
        logic [31:0] back;
        logic [15:0] port;
        logic [15:0] users;
        logic [15:0] limit;
        logic        up;
    } t_request;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   quiet_cycles;
    int   fail_count;
    int   pending;

    llss_req_if req_bus ();
    llss_rsp_if rsp_bus ();

    least_loaded_server_selector dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    least_loaded_server_selector_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_bus),
        .i_rsp        (rsp_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk) begin
        rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_request req_word(
        input t_req_type   kind,
        input logic [3:0]  slot,
        input logic        up = 1'b0,
        input logic [15:0] users = '0,
        input logic [15:0] limit = '0,
        input logic [31:0] prim = '0,
        input logic [31:0] back = '0,
        input logic [15:0] port = '0
    );
        t_request r;
        r.kind  = kind;
        r.slot  = slot;
        r.up    = up;
        r.users = users;
        r.limit = limit;
        r.prim  = prim;
        r.back  = back;
        r.port  = port;
        return r;
    endfunction

    function automatic t_request random_request();
        t_request r;
        int       pick;
        r.slot = 4'($urandom_range(15));
        r.prim = $urandom();
        r.back = $urandom();
        r.port = 16'($urandom());
        r.up   = 1'($urandom_range(1));
        pick = $urandom_range(9);
        if (pick < 7) begin
            r.users = 16'($urandom_range(6));
        end else if (pick == 7) begin
            r.users = 16'($urandom_range(16'hFFFF, 16'hFFFA));
        end else begin
            r.users = 16'($urandom());
        end
        pick = $urandom_range(9);
        if (pick < 6) begin
            r.limit = 16'($urandom_range(12));
        end else if (pick == 6) begin
            r.limit = 16'hFFFF;
        end else begin
            r.limit = 16'($urandom());
        end
        pick = $urandom_range(99);
        if (pick < 25) begin
            r.kind = REQ_REGISTER;
        end else if (pick < 33) begin
            r.kind = REQ_REMOVE;
        end else if (pick < 73) begin
            r.kind = REQ_UPDATE;
        end else begin
            r.kind = REQ_SELECT;
        end
        return r;
    endfunction

    task automatic send_request(input t_request r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.req_type     <= r.kind;
        req_bus.server_slot  <= r.slot;
        req_bus.primary_addr <= r.prim;
        req_bus.backup_addr  <= r.back;
        req_bus.server_port  <= r.port;
        req_bus.start_users  <= r.users;
        req_bus.user_limit   <= r.limit;
        req_bus.count_up     <= r.up;
        @(posedge clk);
        while (!req_bus.ready) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic drain_replies();
        req_bus.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 31;
        recv_idle_pct = 65;
        req_bus.valid = 1'b0;
        req_bus.req_type = REQ_REGISTER;
        req_bus.server_slot = '0;
        req_bus.primary_addr = '0;
        req_bus.backup_addr = '0;
        req_bus.server_port = '0;
        req_bus.start_users = '0;
        req_bus.user_limit = '0;
        req_bus.count_up = 1'b0;
        rsp_bus.ready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table, then ties, full slots, count bounds and re-registration.
        send_request(req_word(REQ_SELECT, 4'd0));
        send_request(req_word(REQ_REMOVE, 4'd3));
        send_request(req_word(REQ_UPDATE, 4'd5, 1'b1));
        send_request(req_word(REQ_REGISTER, 4'd0, 1'b1, 16'd0, 16'hFFFF,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        send_request(req_word(REQ_REGISTER, 4'd15, 1'b0, 16'd0, 16'd1));
        send_request(req_word(REQ_SELECT, 4'd15, 1'b1));
        send_request(req_word(REQ_UPDATE, 4'd15, 1'b1));
        send_request(req_word(REQ_UPDATE, 4'd0, 1'b1));
        send_request(req_word(REQ_SELECT, 4'd0));
        send_request(req_word(REQ_REGISTER, 4'd0, 1'b0, 16'hFFFF, 16'hFFFF,
                              32'hA5A5_5A5A, 32'h5A5A_A5A5, 16'h8001));
        send_request(req_word(REQ_UPDATE, 4'd0, 1'b1));
        send_request(req_word(REQ_SELECT, 4'd0));
        send_request(req_word(REQ_UPDATE, 4'd15, 1'b0));
        send_request(req_word(REQ_SELECT, 4'd0));
        send_request(req_word(REQ_REGISTER, 4'd7, 1'b0, 16'd0, 16'd0,
                              32'h1234_5678, 32'h8765_4321, 16'h0050));
        send_request(req_word(REQ_UPDATE, 4'd7, 1'b0));
        send_request(req_word(REQ_REGISTER, 4'd7, 1'b1, 16'd3, 16'd0,
                              32'hC0A8_0001, 32'h0A00_0001, 16'h1F90));
        send_request(req_word(REQ_REMOVE, 4'd0));
        send_request(req_word(REQ_REMOVE, 4'd15));
        send_request(req_word(REQ_SELECT, 4'd0));
        send_request(req_word(REQ_REMOVE, 4'd7));
        send_request(req_word(REQ_SELECT, 4'd0));
        send_request(req_word(REQ_REMOVE, 4'd7));
        send_request(req_word(REQ_UPDATE, 4'd15, 1'b0));
        drain_replies();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 65 : 0;
            recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 31 : 0;
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                send_request(random_request());
                if ($urandom_range(99) == 0) begin
                    drain_replies();
                end
            end
            drain_replies();
        end

        repeat (40) @(negedge clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/llss_pkg.sv
src/llss_req_if.sv
src/llss_rsp_if.sv
src/llss_ram.sv
src/llss_ctrl.sv
src/llss_dp.sv
src/least_loaded_server_selector.sv
tb/least_loaded_server_selector_checker.sv
tb/least_loaded_server_selector_test.sv
